>>> hdl/fpsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared types, codes and the control store of the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  // Fixed field widths
  localparam int ADDR_W = 40;
  localparam int CNT_W  = 10;
  localparam int UPC_W  = 4;

  // Parameter defaults
  localparam int DEF_MAX_PAGES  = 512;
  localparam int DEF_PAGE_SHIFT = 12;

  // Register reset values
  localparam logic [ADDR_W-1:0] BASE_RST  = 40'h00_8000_0000;
  localparam logic [CNT_W-1:0]  PAGES_RST = 10'd512;

  typedef enum logic [0:0] {
    REG_REGION_BASE  = 1'b0,
    REG_REGION_PAGES = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_INIT     = 2'd0,
    CMD_ALLOC    = 2'd1,
    CMD_FREE     = 2'd2,
    CMD_FREE_RUN = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4,
    ST_BADCOUNT  = 3'd5
  } status_e;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_INIT_SETUP,
    OP_INIT_WRITE,
    OP_POP,
    OP_PAGE,
    OP_CHECK_ADDR,
    OP_CHECK_RANGE,
    OP_CHECK_FULL,
    OP_PUSH,
    OP_RESULT
  } uop_e;

  // Branch conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_DISPATCH,
    C_N_ZERO,
    C_CNT_MORE,
    C_TOP_ZERO,
    C_FAIL,
    C_OUT_BUSY
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  // Program addresses
  localparam upc_t U_FETCH  = 4'd0;
  localparam upc_t U_INIT0  = 4'd1;
  localparam upc_t U_INIT1  = 4'd2;
  localparam upc_t U_ALLOC0 = 4'd3;
  localparam upc_t U_ALLOC1 = 4'd4;
  localparam upc_t U_FREE0  = 4'd5;
  localparam upc_t U_FREE1  = 4'd6;
  localparam upc_t U_FREE2  = 4'd7;
  localparam upc_t U_PUSH   = 4'd8;
  localparam upc_t U_RESULT = 4'd9;

  // Control word: jump to tgt when the condition holds, else go to nxt; dispatch goes to the command entry
  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  tgt;
    upc_t  nxt;
  } uword_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic n_zero;
    logic cnt_more;
    logic top_zero;
    logic fail;
    logic out_busy;
  } flags_t;

  // Control store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    case (a)
      U_FETCH:  w = '{OP_LATCH,       C_DISPATCH, U_FETCH,  U_FETCH};
      U_INIT0:  w = '{OP_INIT_SETUP,  C_N_ZERO,   U_RESULT, U_INIT1};
      U_INIT1:  w = '{OP_INIT_WRITE,  C_CNT_MORE, U_INIT1,  U_RESULT};
      U_ALLOC0: w = '{OP_POP,         C_TOP_ZERO, U_RESULT, U_ALLOC1};
      U_ALLOC1: w = '{OP_PAGE,        C_NEXT,     U_RESULT, U_RESULT};
      U_FREE0:  w = '{OP_CHECK_ADDR,  C_FAIL,     U_RESULT, U_FREE1};
      U_FREE1:  w = '{OP_CHECK_RANGE, C_FAIL,     U_RESULT, U_FREE2};
      U_FREE2:  w = '{OP_CHECK_FULL,  C_FAIL,     U_RESULT, U_PUSH};
      U_PUSH:   w = '{OP_PUSH,        C_CNT_MORE, U_PUSH,   U_RESULT};
      U_RESULT: w = '{OP_RESULT,      C_OUT_BUSY, U_RESULT, U_FETCH};
      default:  w = '{OP_NOP,         C_NEXT,     U_FETCH,  U_FETCH};
    endcase
    return w;
  endfunction

  // Entry point of each command
  function automatic upc_t entry(cmd_e c);
    upc_t a;
    case (c)
      CMD_INIT:     a = U_INIT0;
      CMD_ALLOC:    a = U_ALLOC0;
      CMD_FREE:     a = U_FREE0;
      CMD_FREE_RUN: a = U_FREE0;
      default:      a = U_FETCH;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> hdl/fpsa_stack_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_stack_ram
// Single-port stack memory with registered read data.
// ----------------------------------------------------------------------------
module fpsa_stack_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle, read or write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/fpsa_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_sequencer
// Micro-program counter and control store; issues one control word a cycle.
// ----------------------------------------------------------------------------
module fpsa_sequencer
  import fpsa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] cmd_i,
  input  wire flags_t     flags_i,
  output uop_e            op_o,
  output logic            in_ready_o
);

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   take;

  assign uw         = ucode(upc_q);
  assign op_o       = uw.op;
  assign in_ready_o = (upc_q == U_FETCH);

  // Branch resolution
  always_comb begin
    take  = 1'b0;
    upc_d = uw.nxt;
    case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_DISPATCH: take = 1'b0;
      C_N_ZERO:   take = flags_i.n_zero;
      C_CNT_MORE: take = flags_i.cnt_more;
      C_TOP_ZERO: take = flags_i.top_zero;
      C_FAIL:     take = flags_i.fail;
      C_OUT_BUSY: take = flags_i.out_busy;
      default:    take = 1'b0;
    endcase
    if (uw.cond == C_DISPATCH) begin
      upc_d = in_valid_i ? entry(cmd_e'(cmd_i)) : upc_q;
    end else if (take) begin
      upc_d = uw.tgt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/fpsa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpsa_datapath
// Counters, address arithmetic, checks, stack memory and result register.
// ----------------------------------------------------------------------------
module fpsa_datapath
  import fpsa_pkg::*;
#(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire uop_e              op_i,
  output flags_t                 flags_o,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [ADDR_W-1:0] cfg_wdata_i,
  // input transaction
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [CNT_W-1:0]  run_length_i,
  // result transaction
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             status_o,
  output logic [ADDR_W-1:0]      page_address_o,
  output logic [CNT_W-1:0]       free_count_o,
  output logic [CNT_W-1:0]       used_count_o
);

  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int IW  = $clog2(MAX_PAGES);
  localparam int IXW = ADDR_W - PAGE_SHIFT;
  localparam int EW  = CW + CNT_W;

  // configuration registers
  logic [ADDR_W-1:0] base_q;
  logic [CNT_W-1:0]  pages_q;

  // control state
  logic [CW-1:0] top_q, top_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] used_q, used_d;
  logic          out_valid_q, out_valid_d;

  // working registers
  cmd_e              cmd_q, cmd_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     val_q, val_d;
  logic [IXW-1:0]    idx_q, idx_d;
  status_e           status_q, status_d;
  logic [ADDR_W-1:0] page_q, page_d;

  // result register
  status_e           ostat_q, ostat_d;
  logic [ADDR_W-1:0] opage_q, opage_d;
  logic [CNT_W-1:0]  ofree_q, ofree_d;
  logic [CNT_W-1:0]  oused_q, oused_d;

  // memory port
  logic          ram_en, ram_we;
  logic [IW-1:0] ram_addr, ram_wdata, ram_rdata;

  // derived values
  logic [IXW-1:0]    base_pg;
  logic [EW-1:0]     pages_ext, run_ext, top_ext, used_ext;
  logic [CW-1:0]     n_sat;
  logic              run_bad;
  logic [ADDR_W-1:0] off_diff;
  logic [IXW-1:0]    total_ext;
  logic [CW-1:0]     room;
  logic              range_bad;
  logic [CW:0]       sum_top;
  logic              full_bad;
  logic [CW-1:0]     first_last;
  logic [CW-1:0]     used_rel;
  logic [CW-1:0]     top_m1;
  logic [IXW-1:0]    page_sum;
  logic              out_busy;
  status_e           chk;

  assign base_pg   = base_q[ADDR_W-1:PAGE_SHIFT];
  assign pages_ext = {{CW{1'b0}}, pages_q};
  assign run_ext   = {{CW{1'b0}}, run_q};
  assign top_ext   = {{CNT_W{1'b0}}, top_q};
  assign used_ext  = {{CNT_W{1'b0}}, used_q};

  // init size saturates at stack depth
  assign n_sat   = (pages_ext > EW'(MAX_PAGES)) ? CW'(MAX_PAGES) : pages_ext[CW-1:0];
  assign run_bad = (run_q == '0) || (run_ext > EW'(MAX_PAGES));

  // page index from the current base, modulo address space
  assign off_diff  = addr_q - {base_pg, {PAGE_SHIFT{1'b0}}};
  assign total_ext = {{(IXW-CW){1'b0}}, total_q};
  assign room      = total_q - idx_q[CW-1:0];
  assign range_bad = (idx_q >= total_ext) || (cnt_q > room);

  assign sum_top    = {1'b0, top_q} + {1'b0, cnt_q};
  assign full_bad   = sum_top > {1'b0, total_q};
  assign first_last = idx_q[CW-1:0] + cnt_q - CW'(1);
  assign used_rel   = (used_q > cnt_q) ? (used_q - cnt_q) : '0;
  assign top_m1     = top_q - CW'(1);
  assign page_sum   = base_pg + {{(IXW-IW){1'b0}}, ram_rdata};
  assign out_busy   = out_valid_q && !out_ready_i;

  // micro-operation decode
  always_comb begin
    top_d       = top_q;
    total_d     = total_q;
    used_d      = used_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    idx_d       = idx_q;
    status_d    = status_q;
    page_d      = page_q;
    ostat_d     = ostat_q;
    opage_d     = opage_q;
    ofree_d     = ofree_q;
    oused_d     = oused_q;
    out_valid_d = out_valid_q && !out_ready_i;
    chk         = ST_OK;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = top_q[IW-1:0];
    ram_wdata   = val_q;

    case (op_i)
      OP_LATCH: begin
        if (in_valid_i) begin
          cmd_d    = cmd_e'(cmd_i);
          addr_d   = address_i;
          run_d    = run_length_i;
          status_d = ST_OK;
          page_d   = '0;
        end
      end
      OP_INIT_SETUP: begin
        top_d   = n_sat;
        total_d = n_sat;
        used_d  = '0;
        cnt_d   = n_sat;
        val_d   = '0;
      end
      OP_INIT_WRITE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = val_q;
        ram_wdata = val_q;
        val_d     = val_q + IW'(1);
        cnt_d     = cnt_q - CW'(1);
      end
      OP_POP: begin
        if (top_q != '0) begin
          ram_en   = 1'b1;
          ram_addr = top_m1[IW-1:0];
          top_d    = top_m1;
        end else begin
          status_d = ST_EMPTY;
        end
      end
      OP_PAGE: begin
        page_d = {page_sum, {PAGE_SHIFT{1'b0}}};
        used_d = used_q + CW'(1);
      end
      OP_CHECK_ADDR: begin
        cnt_d = (cmd_q == CMD_FREE) ? CW'(1) : run_ext[CW-1:0];
        if ((cmd_q == CMD_FREE_RUN) && run_bad) begin
          chk = ST_BADCOUNT;
        end else if (addr_q[PAGE_SHIFT-1:0] != '0) begin
          chk = ST_UNALIGNED;
        end
        idx_d    = off_diff[ADDR_W-1:PAGE_SHIFT];
        status_d = chk;
      end
      OP_CHECK_RANGE: begin
        if (range_bad) begin
          chk = ST_RANGE;
        end
        status_d = chk;
      end
      OP_CHECK_FULL: begin
        if (full_bad) begin
          chk = ST_FULL;
        end else begin
          val_d  = first_last[IW-1:0];
          used_d = used_rel;
        end
        status_d = chk;
      end
      OP_PUSH: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = top_q[IW-1:0];
        ram_wdata = val_q;
        top_d     = top_q + CW'(1);
        val_d     = val_q - IW'(1);
        cnt_d     = cnt_q - CW'(1);
      end
      OP_RESULT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          ostat_d     = status_q;
          opage_d     = page_q;
          ofree_d     = top_ext[CNT_W-1:0];
          oused_d     = used_ext[CNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // flags for the sequencer
  assign flags_o.n_zero   = (n_sat == '0);
  assign flags_o.cnt_more = (cnt_q != CW'(1));
  assign flags_o.top_zero = (top_q == '0);
  assign flags_o.fail     = (chk != ST_OK);
  assign flags_o.out_busy = out_busy;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      pages_q <= PAGES_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_REGION_BASE:  base_q  <= cfg_wdata_i;
        REG_REGION_PAGES: pages_q <= cfg_wdata_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      total_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      top_q       <= top_d;
      total_q     <= total_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    addr_q   <= addr_d;
    run_q    <= run_d;
    cnt_q    <= cnt_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    page_q   <= page_d;
    ostat_q  <= ostat_d;
    opage_q  <= opage_d;
    ofree_q  <= ofree_d;
    oused_q  <= oused_d;
  end

  fpsa_stack_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (IW)
  ) u_stack (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = ostat_q;
  assign page_address_o = opage_q;
  assign free_count_o   = ofree_q;
  assign used_count_o   = oused_q;

  // pages on the stack plus pages handed out never exceed the region
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, used_q} + {1'b0, top_q}) <= {1'b0, total_q})
    else $error("free plus used count exceeds region size");

  // a push always has room below the region size
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_PUSH) |-> (top_q < total_q))
    else $error("push beyond region size");

  // page address is formed only right after a successful pop
  a_page_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_PAGE) |-> ($past(op_i) == OP_POP) && ($past(top_q) != '0))
    else $error("page formed without a stack read");

endmodule
`default_nettype wire

>>> hdl/free_page_stack_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// free_page_stack_allocator_unit
// LIFO free-page allocator run by a small microprogram over a stack RAM.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------
//  cfg     | in        | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//  in      | in        | in_valid_i / in_ready_o  | cmd_i, address_i,
//          |           |                          | run_length_i
//  out     | out       | out_valid_o / out_ready_i| status_o, page_address_o,
//          |           |                          | free_count_o, used_count_o
//
//  From input transaction to result register, one micro-step a cycle: allocate
//  pops the stack and forms the page; free page and free run check address,
//  range and room, then push each page; init sets the counts and writes each
//  region page, if any; failed checks end early. Then fetch takes the next command.
//  Reset: stack empty, counts zero; stack RAM needs no clearing.
//  A result waits in its output register while the next command is taken;
//  the sequencer holds only if a second result finds that register full.
module free_page_stack_allocator_unit
  import fpsa_pkg::*;
#(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [ADDR_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [CNT_W-1:0]  run_length_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             status_o,
  output logic [ADDR_W-1:0]      page_address_o,
  output logic [CNT_W-1:0]       free_count_o,
  output logic [CNT_W-1:0]       used_count_o
);

  uop_e   op;
  flags_t flags;

  fpsa_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .flags_i    (flags),
    .op_o       (op),
    .in_ready_o (in_ready_o)
  );

  fpsa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .flags_o        (flags),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .cmd_i          (cmd_i),
    .address_i      (address_i),
    .run_length_i   (run_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .page_address_o (page_address_o),
    .free_count_o   (free_count_o),
    .used_count_o   (used_count_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_free_page_stack_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_page_stack_allocator_unit
// Self-checking bench for the free page stack allocator. A cycle-free model of
// the page stack predicts status, page address and counts for every accepted
// command; results are compared in order. Directed cases cover region extremes,
// address wrap, check priority and base moves; random bursts then run
// alloc/free traffic under four idling mixes on both handshakes.
// ----------------------------------------------------------------------------
module tb_free_page_stack_allocator_unit
  import fpsa_pkg::*;
();

  localparam int MAX_PAGES      = DEF_MAX_PAGES;
  localparam int PAGE_SHIFT     = DEF_PAGE_SHIFT;
  localparam int IDX_W          = $clog2(MAX_PAGES);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 600;

  // Expected result of one command
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] page;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  used_cnt;
  } alloc_result_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic              cfg_index_i  = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata_i  = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [1:0]        cmd_i        = '0;
  logic [ADDR_W-1:0] address_i    = '0;
  logic [CNT_W-1:0]  run_length_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [2:0]        status_o;
  logic [ADDR_W-1:0] page_address_o;
  logic [CNT_W-1:0]  free_count_o;
  logic [CNT_W-1:0]  used_count_o;

  // Shadow of the allocator state
  logic [ADDR_W-1:0] model_base  = BASE_RST;
  logic [CNT_W-1:0]  model_pages = PAGES_RST;
  logic [IDX_W-1:0]  model_stack [MAX_PAGES];
  int unsigned       model_top   = 0;
  int unsigned       model_total = 0;
  int unsigned       model_used  = 0;
  int unsigned       held_idx[$];      // pages handed out, used to build frees

  alloc_result_t pending_results[$];
  alloc_result_t head_result;
  int            errors          = 0;
  int            cmds_sent       = 0;
  int            results_checked = 0;
  int            status_seen [6] = '{default: 0};
  int            send_idle_pct   = 0;
  int            out_stall_pct   = 0;
  int            idle_cycles     = 0;

  free_page_stack_allocator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .address_i      (address_i),
    .run_length_i   (run_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .page_address_o (page_address_o),
    .free_count_o   (free_count_o),
    .used_count_o   (used_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d page %h", status_o, page_address_o);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, status_o);
          errors++;
        end
        if (page_address_o !== head_result.page) begin
          $error("page_address: expected %h, actual %h", head_result.page, page_address_o);
          errors++;
        end
        if (free_count_o !== head_result.free_cnt) begin
          $error("free_count: expected %0d, actual %0d", head_result.free_cnt, free_count_o);
          errors++;
        end
        if (used_count_o !== head_result.used_cnt) begin
          $error("used_count: expected %0d, actual %0d", head_result.used_cnt, used_count_o);
          errors++;
        end
        results_checked++;
      end
      if (status_o <= ST_BADCOUNT) status_seen[status_o]++;
    end
  end

  function automatic logic [ADDR_W-1:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // Byte address of a page index under the current base (low bits dropped)
  function automatic logic [ADDR_W-1:0] pg_byte_addr(input int unsigned idx);
    return {model_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
           + (ADDR_W'(idx) << PAGE_SHIFT);
  endfunction

  // Applies one command to the shadow stack and gives its result
  task automatic predict_page_op(input cmd_e c, input logic [ADDR_W-1:0] addr,
                                 input logic [CNT_W-1:0] run, output alloc_result_t want);
    logic [ADDR_W-1:0] offs;
    int unsigned       idx;
    int unsigned       cnt;
    int unsigned       i;
    want.status = ST_OK;
    want.page   = '0;
    case (c)
      CMD_INIT: begin
        cnt = (model_pages > MAX_PAGES) ? MAX_PAGES : model_pages;
        for (i = 0; i < cnt; i++) model_stack[i] = IDX_W'(i);
        model_top   = cnt;
        model_total = cnt;
        model_used  = 0;
        held_idx.delete();
      end
      CMD_ALLOC: begin
        if (model_top == 0) begin
          want.status = ST_EMPTY;
        end else begin
          model_top--;
          idx       = model_stack[model_top];
          want.page = pg_byte_addr(idx);
          model_used++;
          held_idx.push_back(idx);
        end
      end
      default: begin
        cnt  = (c == CMD_FREE) ? 1 : run;
        offs = addr - pg_byte_addr(0);
        idx  = offs[ADDR_W-1:PAGE_SHIFT];
        if (c == CMD_FREE_RUN && (run == 0 || run > MAX_PAGES)) begin
          want.status = ST_BADCOUNT;
        end else if (addr[PAGE_SHIFT-1:0] != '0) begin
          want.status = ST_UNALIGNED;
        end else if (idx >= model_total || cnt > model_total - idx) begin
          want.status = ST_RANGE;
        end else if (model_top + cnt > model_total) begin
          want.status = ST_FULL;
        end else begin
          // run goes on in reverse so its first page ends on top
          for (i = cnt; i > 0; i--) begin
            model_stack[model_top] = IDX_W'(idx + i - 1);
            model_top++;
          end
          model_used = (model_used > cnt) ? model_used - cnt : 0;
        end
      end
    endcase
    want.free_cnt = model_top[CNT_W-1:0];
    want.used_cnt = model_used[CNT_W-1:0];
  endtask

  // One input transaction; valid stays up until the next call or a drain
  task automatic send_cmd(input cmd_e c, input logic [ADDR_W-1:0] addr,
                          input logic [CNT_W-1:0] run);
    alloc_result_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    address_i    <= addr;
    run_length_i <= run;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_page_op(c, addr, run, want);
    pending_results.push_back(want);
    cmds_sent++;
  endtask

  // Sender stops until every pending result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Register write, always with the block idle
  task automatic cfg_write(input cfg_reg_e idx, input logic [ADDR_W-1:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_REGION_BASE) model_base = data;
    else model_pages = data[CNT_W-1:0];
  endtask

  // Nothing initialized yet: empty stack, zero-size region
  task automatic test_after_reset();
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE, pg_byte_addr(0), '0);
    send_cmd(CMD_FREE_RUN, pg_byte_addr(0), '0);
  endtask

  // Empty region, saturated region size, full stack and bad counts
  task automatic test_region_extremes();
    cfg_write(REG_REGION_PAGES, '0);
    send_cmd(CMD_INIT, '0, '0);
    send_cmd(CMD_ALLOC, '0, '0);
    cfg_write(REG_REGION_BASE, '0);
    cfg_write(REG_REGION_PAGES, 40'd1000);
    send_cmd(CMD_INIT, '0, '0);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE_RUN, pg_byte_addr(0), CNT_W'(MAX_PAGES));
    send_cmd(CMD_FREE, pg_byte_addr(MAX_PAGES - 1), '0);
    send_cmd(CMD_FREE_RUN, pg_byte_addr(0), CNT_W'(MAX_PAGES + 1));
    send_cmd(CMD_FREE_RUN, {ADDR_W{1'b1}}, {CNT_W{1'b1}});
  endtask

  // Region at the top of the address space wraps; check priority on frees
  task automatic test_base_wrap();
    cfg_write(REG_REGION_BASE, {ADDR_W{1'b1}});
    cfg_write(REG_REGION_PAGES, 40'd4);
    send_cmd(CMD_INIT, '0, '0);
    repeat (5) send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE_RUN, pg_byte_addr(0), 10'd4);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE_RUN, pg_byte_addr(1) | 40'h1, '0);
    send_cmd(CMD_FREE, pg_byte_addr(0) | 40'h800, '0);
    send_cmd(CMD_FREE, pg_byte_addr(0) - 40'h1000, '0);
    send_cmd(CMD_FREE_RUN, pg_byte_addr(2), 10'd3);
    send_cmd(CMD_FREE, pg_byte_addr(0), '0);
    send_cmd(CMD_FREE, pg_byte_addr(3), '0);
  endtask

  // Base moved after init: addresses follow the new base
  task automatic test_base_moved();
    cfg_write(REG_REGION_BASE, 40'h12_3456_7000);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE, pg_byte_addr(0), '0);
  endtask

  // One random command, mostly well-formed against the shadow state
  task automatic random_command();
    int          r;
    int unsigned idx;
    int unsigned len;
    int unsigned room;
    int          k;
    r = $urandom_range(99);
    if (r < 38) begin
      send_cmd(CMD_ALLOC, rand40(), CNT_W'($urandom_range(1023)));
    end else if (r < 63) begin
      if (held_idx.size() > 0) begin
        k   = $urandom_range(held_idx.size() - 1);
        idx = held_idx[k];
        held_idx.delete(k);
      end else begin
        idx = $urandom_range(model_total);
      end
      send_cmd(CMD_FREE, pg_byte_addr(idx), CNT_W'($urandom_range(1023)));
    end else if (r < 78) begin
      room = model_total - model_top;
      len  = (room > 0) ? $urandom_range(room, 1) : $urandom_range(4, 1);
      idx  = (model_total >= len) ? $urandom_range(model_total - len) : 0;
      send_cmd(CMD_FREE_RUN, pg_byte_addr(idx), CNT_W'(len));
    end else if (r < 82) begin
      send_cmd(CMD_INIT, rand40(), CNT_W'($urandom_range(1023)));
    end else if (r < 88) begin
      // broken free: one offset bit set, or a run past the region
      idx = $urandom_range(model_total);
      if (r < 85) begin
        send_cmd(CMD_FREE, pg_byte_addr(idx) | (40'h1 << $urandom_range(PAGE_SHIFT - 1)), '0);
      end else begin
        send_cmd(CMD_FREE_RUN, pg_byte_addr(idx), CNT_W'(model_total - idx + 1));
      end
    end else begin
      send_cmd(cmd_e'($urandom_range(3)), rand40(), CNT_W'($urandom_range(1023)));
    end
  endtask

  // Bursts on a fresh random region, each set up with the block drained
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int done;
    int burst;
    int r;
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    done          = 0;
    while (done < n_items) begin
      r = $urandom_range(99);
      cfg_write(REG_REGION_BASE, (r < 10) ? {ADDR_W{1'b1}} : (r < 20) ? '0 : rand40());
      r = $urandom_range(99);
      cfg_write(REG_REGION_PAGES,
                (r < 4)  ? ADDR_W'(MAX_PAGES) :
                (r < 7)  ? ADDR_W'($urandom_range(1023, MAX_PAGES + 1)) :
                (r < 10) ? '0 : ADDR_W'($urandom_range(24, 1)));
      send_cmd(CMD_INIT, rand40(), CNT_W'($urandom_range(1023)));
      burst = $urandom_range(80, 30);
      repeat (burst) random_command();
      done += burst + 1;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_region_extremes();
    test_base_wrap();
    test_base_moved();
    test_random_traffic(0, 0, 450);
    test_random_traffic(53, 0, 450);
    test_random_traffic(0, 53, 450);
    test_random_traffic(19, 19, 450);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d results of %0d commands: directed cases and four idling mixes.",
             results_checked, cmds_sent);
    $display("Status mix ok %0d, empty %0d, unaligned %0d, range %0d, full %0d, bad count %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
